// ===== sv/levinson_durbin_lpc_top_assert.svh =====
// Assertion macros for the LPC solver.
`ifndef LEVINSON_DURBIN_LPC_TOP_ASSERT_SVH
`define LEVINSON_DURBIN_LPC_TOP_ASSERT_SVH
// Implication that must hold at every clock edge out of reset.
`define LDL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define LDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/ldl_pkg.sv =====
// Package of shared constants and types for the LPC solver.
`default_nettype none
package ldl_pkg;
  localparam int MAX_ORDER_DEF = 32;
  localparam logic [5:0] ORDER_RESET = 6'd12;
  localparam logic signed [23:0] Q18_ONE = 24'sd262144;
  localparam logic [23:0] Q23_ONE = 24'd8388608;
  localparam logic signed [23:0] C24_MAX = 24'sd8388607;
  localparam logic signed [23:0] C24_MIN = -24'sd8388608;

  typedef struct packed {
    logic        start;
    logic [55:0] num;
    logic [23:0] den;
  } div_req_t;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'sd8388607) r = C24_MAX;
    else if (v < -48'sd8388608) r = C24_MIN;
    else r = v[23:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== sv/ldl_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ldl_div import ldl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire div_req_t    req,
  output logic             done,
  output logic [55:0]      quot
);
  logic [55:0] q_r, q_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [23:0] den_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [24:0] sh;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {rem_r[23:0], q_r[55]};
    if (req.start) begin
      q_nxt = req.num; rem_nxt = '0; cnt_nxt = 6'd55; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r}; q_nxt = {q_r[54:0], 1'b1};
      end else begin
        rem_nxt = sh; q_nxt = {q_r[54:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

// ===== sv/levinson_durbin_lpc_top.sv =====
// Top level of the Levinson-Durbin LPC solver with sequencer and shared multiplier.
// Solving starts after the p-th item and is shorter with zero energy, as the division is skipped.
// Items 1..p-1 are taken one per cycle with start high; busy stays high while solving and emitting.
// Results come one per cycle, p+1 in all, and the receiver cannot stall them.
// Throughput is set by one shared multiplier and one bit-serial divider.
// Synchronous active-low reset restores order 12 and clears the load count.
`default_nettype none
module levinson_durbin_lpc_top import ldl_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_corr_value,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [5:0]         cfg_model_order,
  output logic                    out_strobe,
  output logic signed [23:0]      out_coeff_value,
  output logic [5:0]              out_coeff_index,
  output logic                    out_coeff_last,
  output logic                    out_unstable
);
  `include "levinson_durbin_lpc_top_assert.svh"
  localparam int IW = $clog2(MAX_ORDER + 1);
  localparam int CW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  typedef enum logic [7:0] {
    S_LOAD = 8'b00000001, S_STAGE = 8'b00000010, S_ACC = 8'b00000100,
    S_DIV = 8'b00001000, S_UPD = 8'b00010000, S_ENG = 8'b00100000,
    S_COPY = 8'b01000000, S_EMIT = 8'b10000000
  } st_t;

  st_t st_r, st_nxt;
  logic [5:0] ord_r;
  logic [5:0] cnt_r, cnt_nxt;
  logic [IW-1:0] p_r, p_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic signed [15:0] corr_mem [MAX_ORDER];
  logic signed [23:0] prev_mem [MAX_ORDER+1];
  logic signed [23:0] cur_mem [MAX_ORDER+1];
  logic signed [55:0] acc_r, acc_nxt;
  logic [23:0] e_r, e_nxt;
  logic signed [23:0] k_r, k_nxt;
  logic uns_r, uns_nxt;
  logic signed [23:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic signed [47:0] prod_r;
  logic signed [15:0] crd_r;
  logic signed [23:0] prd_r, prd2_r;
  logic signed [23:0] cpy_r;
  logic [IW-1:0] cpy_idx_r;
  logic cpy_vld_r;
  div_req_t dreq;
  logic ddone;
  logic [55:0] dq;
  logic [IW-1:0] p_eff;
  logic [CW-1:0] cidx;
  logic signed [47:0] rnd;
  logic [36:0] eterm;
  logic [60:0] eprod;

  ldl_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq));

  always_comb begin
    if (ord_r == 6'd0) p_eff = IW'(1);
    else if (32'(ord_r) > MAX_ORDER) p_eff = IW'(MAX_ORDER);
    else p_eff = ord_r[IW-1:0];
  end

  assign busy = (st_r != S_LOAD);
  assign cfg_ready = 1'b1;
  assign rnd = (prod_r + 48'sd131072) >>> 18;
  assign eterm = 37'h10_0000_0000 - 37'(prod_r);
  assign eprod = {37'd0, e_r} * {24'd0, eterm};

  always_comb begin
    cidx = '0;
    unique case (st_r)
      S_ACC: cidx = CW'(i_r - j_r - IW'(1));
      default: cidx = CW'(i_r - IW'(1));
    endcase
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; p_nxt = p_r; i_nxt = i_r; j_nxt = j_r; ph_nxt = ph_r;
    acc_nxt = acc_r; e_nxt = e_r; k_nxt = k_r; uns_nxt = uns_r;
    ma_nxt = ma_r; mb_nxt = mb_r; dreq = '0;
    unique case (st_r)
      S_LOAD: if (start) begin
        cnt_nxt = cnt_r + 6'd1;
        if (32'(cnt_r) + 1 >= 32'(p_eff)) begin
          cnt_nxt = '0; p_nxt = p_eff; i_nxt = IW'(1); e_nxt = Q23_ONE; uns_nxt = 1'b0;
          ph_nxt = '0; st_nxt = S_STAGE;
        end
      end
      S_STAGE: begin
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          acc_nxt = 56'(crd_r) <<< 18; j_nxt = IW'(1); ph_nxt = '0; st_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (j_r >= i_r) begin
          if (ph_r == 2'd3 || i_r == IW'(1)) begin
            if (i_r != IW'(1)) acc_nxt = acc_r + 56'(prod_r);
            ph_nxt = '0;
            st_nxt = S_DIV;
          end else if (ph_r == 2'd0) ph_nxt = 2'd3;
          else ph_nxt = ph_r + 2'd1;
        end else begin
          ph_nxt = ph_r + 2'd1;
          if (ph_r == 2'd1) begin ma_nxt = prd_r; mb_nxt = 24'(crd_r); end
          if (ph_r == 2'd3) begin
            if (j_r != IW'(1)) acc_nxt = acc_r + 56'(prod_r);
            ph_nxt = 2'd1; j_nxt = j_r + IW'(1);
            ma_nxt = prd_r; mb_nxt = 24'(crd_r);
            if (j_r + IW'(1) >= i_r) ph_nxt = 2'd0;
          end
        end
      end
      S_DIV: begin
        if (ph_r == 2'd0) begin
          if (e_r == '0) begin
            uns_nxt = 1'b1; k_nxt = '0; j_nxt = IW'(1); st_nxt = S_UPD;
          end else begin
            dreq.start = 1'b1;
            dreq.num = (acc_r < 0 ? 56'(-acc_r) : 56'(acc_r)) << 8;
            dreq.den = e_r; ph_nxt = 2'd1;
          end
        end else if (ddone) begin
          if (dq >= 56'(Q18_ONE)) uns_nxt = 1'b1;
          if (acc_r > 0) k_nxt = (dq > 56'd8388608) ? C24_MIN : -$signed(24'(dq));
          else k_nxt = (dq > 56'd8388607) ? C24_MAX : $signed(24'(dq));
          ph_nxt = '0; j_nxt = IW'(1); st_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (j_r >= i_r) begin ph_nxt = '0; st_nxt = S_ENG; ma_nxt = k_r; mb_nxt = k_r; end
        else begin
          ph_nxt = ph_r + 2'd1;
          if (ph_r == 2'd1) begin ma_nxt = k_r; mb_nxt = prd_r; end
          if (ph_r == 2'd3) begin ph_nxt = '0; j_nxt = j_r + IW'(1); end
        end
      end
      S_ENG: begin
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd1) begin
          if (k_r >= Q18_ONE || k_r <= -Q18_ONE) e_nxt = '0;
          else e_nxt = eprod[59:36];
          ph_nxt = 2'd2;
        end
        if (ph_r == 2'd2) begin
          if (e_r == '0) uns_nxt = 1'b1;
          ph_nxt = '0; j_nxt = IW'(1); st_nxt = S_COPY;
        end
      end
      S_COPY: begin
        j_nxt = j_r + IW'(1);
        if (j_r >= i_r) begin
          if (i_r >= p_r) begin j_nxt = '0; st_nxt = S_EMIT; end
          else begin i_nxt = i_r + IW'(1); ph_nxt = '0; st_nxt = S_STAGE; end
        end
      end
      S_EMIT: begin
        j_nxt = j_r + IW'(1);
        if (j_r >= p_r) st_nxt = S_LOAD;
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; ord_r <= ORDER_RESET; cnt_r <= '0;
      out_strobe <= 1'b0; cpy_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt;
      if (cfg_valid) ord_r <= cfg_model_order;
      out_strobe <= (st_r == S_EMIT);
      cpy_vld_r <= (st_r == S_COPY && j_r <= i_r);
    end
    p_r <= p_nxt; i_r <= i_nxt; j_r <= j_nxt; ph_r <= ph_nxt;
    acc_r <= acc_nxt; e_r <= e_nxt; k_r <= k_nxt; uns_r <= uns_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt;
    prod_r <= ma_r * mb_r;
    crd_r <= corr_mem[cidx];
    prd_r <= (st_r == S_UPD) ? prev_mem[i_r - j_r] : prev_mem[j_r];
    prd2_r <= prev_mem[j_r];
    cpy_r <= cur_mem[j_r];
    cpy_idx_r <= j_r;
    if (st_r == S_LOAD && start && 32'(cnt_r) < MAX_ORDER)
      corr_mem[cnt_r[CW-1:0]] <= in_corr_value;
    if (st_r == S_DIV && st_nxt == S_UPD) cur_mem[i_r] <= k_nxt;
    if (st_r == S_UPD && ph_r == 2'd3 && j_r < i_r)
      cur_mem[j_r] <= sat24(48'(prd2_r) + rnd);
    if (cpy_vld_r) prev_mem[cpy_idx_r] <= cpy_r;
    if (st_r == S_EMIT) begin
      out_coeff_value <= (j_r == '0) ? Q18_ONE : prev_mem[j_r];
      out_coeff_index <= 6'(j_r);
      out_coeff_last <= (j_r >= p_r);
      out_unstable <= uns_r;
    end
  end

  `LDL_ASSERT_IMP(a_busy_emit, clk, rst_n, out_strobe, busy || out_coeff_last)
  `LDL_ASSERT_IMP(a_idx_range, clk, rst_n, out_strobe, out_coeff_index <= 6'(p_r))
  `LDL_ASSERT_NEXT(a_last_idle, clk, rst_n, out_strobe && out_coeff_last, !out_strobe)
endmodule
`default_nettype wire
